// ===== rtl/beep_pattern_generator_top_assert.svh =====
// Assertion macros used by the beeper pattern RTL
`ifndef BEEP_PATTERN_GENERATOR_TOP_ASSERT_SVH
`define BEEP_PATTERN_GENERATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define BPG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define BPG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define BPG_ASSERT(lbl, prop, msg)
`define BPG_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/bpg_pkg.sv =====
// Types and constants of the beeper pattern generator
package bpg_pkg;

    localparam logic [15:0] POLL_TICKS    = 16'd20;
    localparam logic [15:0] DEFAULT_SHORT = 16'd50;

    // item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_SHORT = 2'd1;
    localparam logic [1:0] KIND_ALARM = 2'd2;
    localparam logic [1:0] KIND_STOP  = 2'd3;

    // configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_AUDIBLE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_PRESENT = 3'd4;

    typedef enum logic [1:0] {
        PH_POLL  = 2'd0,
        PH_SHORT = 2'd1,
        PH_ON    = 2'd2,
        PH_OFF   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] short_ms;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
        logic [15:0] repeat_count;
    } in_item_t;

    typedef struct packed {
        logic tone_on;
        logic alarm_active;
        logic short_waiting;
    } out_item_t;

endpackage

// ===== rtl/bpg_cfg.sv =====
// APB register file: audible_enable and hardware_present
module bpg_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpg_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic                            allowed
);
    import bpg_pkg::*;

    logic audible_reg;
    logic audible_next;
    logic present_reg;
    logic present_next;
    logic wr_en;
    logic rd_bit;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb
    begin
        audible_next = audible_reg;
        present_next = present_reg;
        if (wr_en)
        begin
            unique case (paddr)
                ADDR_AUDIBLE: audible_next = pwdata[0];
                ADDR_PRESENT: present_next = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            audible_reg <= 1'b1;
            present_reg <= 1'b1;
        end
        else
        begin
            audible_reg <= audible_next;
            present_reg <= present_next;
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_AUDIBLE: rd_bit = audible_reg;
            ADDR_PRESENT: rd_bit = present_reg;
            default:      rd_bit = 1'b0;
        endcase
    end

    assign prdata  = {31'd0, rd_bit};
    assign allowed = audible_reg & present_reg;

endmodule

// ===== rtl/bpg_core.sv =====
// Pattern state: poll wait, short beep, alarm on/off cycles
module bpg_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  bpg_pkg::in_item_t  item,
    input  logic               allowed,
    output bpg_pkg::out_item_t result
);
    import bpg_pkg::*;

    `include "beep_pattern_generator_top_assert.svh"

    phase_t      phase_reg,      phase_next;
    logic [15:0] countdown_reg,  countdown_next;
    logic [15:0] pending_reg,    pending_next;
    logic [15:0] pat_on_reg,     pat_on_next;
    logic [15:0] pat_off_reg,    pat_off_next;
    logic [15:0] pat_rep_reg,    pat_rep_next;
    logic [15:0] cycles_reg,     cycles_next;
    logic        alarm_reg,      alarm_next;
    logic        drive_reg,      drive_next;

    logic        do_cycle;   // start next on/off cycle or finish
    logic [15:0] cyc;
    logic        tone_phase;
    logic        short_req;

    always_comb
    begin
        phase_next     = phase_reg;
        countdown_next = countdown_reg;
        pending_next   = pending_reg;
        pat_on_next    = pat_on_reg;
        pat_off_next   = pat_off_reg;
        pat_rep_next   = pat_rep_reg;
        cycles_next    = cycles_reg;
        alarm_next     = alarm_reg;
        drive_next     = drive_reg;
        do_cycle       = 1'b0;
        cyc            = cycles_reg;

        case (item.kind)
            KIND_TICK:
            begin
                if (countdown_reg > 16'd1)
                begin
                    countdown_next = countdown_reg - 16'd1;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_POLL:
                        begin
                            if (pending_reg != 16'd0)
                            begin
                                countdown_next = pending_reg;
                                pending_next   = 16'd0;
                                phase_next     = PH_SHORT;
                                drive_next     = 1'b1;
                            end
                            else if (alarm_reg)
                            begin
                                do_cycle = 1'b1;
                                cyc      = pat_rep_reg;
                            end
                            else
                            begin
                                phase_next     = PH_POLL;
                                countdown_next = POLL_TICKS;
                                drive_next     = 1'b0;
                            end
                        end
                        PH_SHORT:
                        begin
                            drive_next = 1'b0;
                            if (alarm_reg)
                            begin
                                do_cycle = 1'b1;
                                cyc      = pat_rep_reg;
                            end
                            else
                            begin
                                phase_next     = PH_POLL;
                                countdown_next = POLL_TICKS;
                            end
                        end
                        PH_ON:
                        begin
                            drive_next     = 1'b0;
                            phase_next     = PH_OFF;
                            countdown_next = pat_off_reg;
                        end
                        PH_OFF:
                        begin
                            do_cycle = 1'b1;
                            if (pat_rep_reg != 16'd0 && cycles_reg != 16'd0)
                                cyc = cycles_reg - 16'd1;
                        end
                        default: ;
                    endcase

                    if (do_cycle)
                    begin
                        cycles_next = cyc;
                        if (alarm_reg && (cyc != 16'd0 || pat_rep_reg == 16'd0))
                        begin
                            phase_next     = PH_ON;
                            countdown_next = pat_on_reg;
                            drive_next     = 1'b1;
                        end
                        else
                        begin
                            alarm_next     = 1'b0;
                            phase_next     = PH_POLL;
                            countdown_next = POLL_TICKS;
                            drive_next     = 1'b0;
                        end
                    end
                end
            end
            KIND_SHORT:
            begin
                if (allowed)
                    pending_next = (item.short_ms != 16'd0) ? item.short_ms : DEFAULT_SHORT;
            end
            KIND_ALARM:
            begin
                if (allowed)
                begin
                    pat_on_next  = item.on_ms;
                    pat_off_next = item.off_ms;
                    pat_rep_next = item.repeat_count;
                    alarm_next   = 1'b1;
                    cycles_next  = item.repeat_count;
                    // restart at once if a cycle is running
                    if (phase_reg == PH_ON || phase_reg == PH_OFF)
                    begin
                        phase_next     = PH_ON;
                        countdown_next = item.on_ms;
                        drive_next     = 1'b1;
                    end
                end
            end
            default:
            begin
                alarm_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_POLL;
            countdown_reg <= POLL_TICKS;
            pending_reg   <= 16'd0;
            pat_on_reg    <= 16'd0;
            pat_off_reg   <= 16'd0;
            pat_rep_reg   <= 16'd0;
            cycles_reg    <= 16'd0;
            alarm_reg     <= 1'b0;
            drive_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            countdown_reg <= countdown_next;
            pending_reg   <= pending_next;
            pat_on_reg    <= pat_on_next;
            pat_off_reg   <= pat_off_next;
            pat_rep_reg   <= pat_rep_next;
            cycles_reg    <= cycles_next;
            alarm_reg     <= alarm_next;
            drive_reg     <= drive_next;
        end
    end

    assign result.tone_on       = drive_next;
    assign result.alarm_active  = alarm_next;
    assign result.short_waiting = (pending_next != 16'd0);

    assign tone_phase = (phase_reg == PH_SHORT) || (phase_reg == PH_ON);
    assign short_req  = step && (item.kind == KIND_SHORT) && allowed;

    // tone is on exactly while a short beep or an alarm on time plays
    `BPG_ASSERT(a_drive_phase, drive_reg == tone_phase, "drive out of step with phase")
    `BPG_ASSERT(a_short_held, short_req |=> pending_reg != 16'd0, "short request not held")
    `BPG_ASSERT(a_stop_clears, step && item.kind == KIND_STOP |=> !alarm_reg, "stop left alarm set")

endmodule

// ===== rtl/beep_pattern_generator_top.sv =====
// An accepted item passes the input reg, then the result reg, before out_valid rises.
// Throughput: one item per cycle while the output is not stalled; the state update is a single pass of short logic.
// A stalled result holds the result register; one more item waits in the input reg.
// Reset (rst_n, async low): poll wait with a 20 ms countdown, no beep or alarm pending,
//   both enable registers set.
module beep_pattern_generator_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  bpg_pkg::in_item_t               in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output bpg_pkg::out_item_t              out_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpg_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import bpg_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      advance;
    logic      allowed;
    out_item_t result;

    // input register may move on when the result register frees up
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_item;
        if (advance && in_valid_reg)
            out_item_reg <= result;
    end

    bpg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .allowed (allowed)
    );

    bpg_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (in_valid_reg && advance),
        .item    (in_item_reg),
        .allowed (allowed),
        .result  (result)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== dv/beep_pattern_checker.sv =====
// Checker for the beeper pattern generator: tracks the pattern state and compares every result
`timescale 1ns / 1ps

module beep_pattern_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  bpg_pkg::in_item_t               in_item,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  bpg_pkg::out_item_t              out_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [bpg_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output int                              errors,
    output int                              pending,
    output int                              checked,
    output int                              tone_count
);
    import bpg_pkg::*;

    // shadow of the pattern state
    phase_t      ph;
    logic [15:0] remaining;
    logic [15:0] short_len;
    logic [15:0] tone_len;
    logic [15:0] gap_len;
    logic [15:0] cycle_total;
    logic [15:0] cycles_todo;
    logic        alarm_req;
    logic        tone;
    logic        audible;
    logic        present;

    out_item_t   predicted_outputs[$];
    out_item_t   want;

    task automatic report(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        errors++;
    endtask

    function void to_poll_wait();
        ph        = PH_POLL;
        remaining = POLL_TICKS;
        tone      = 1'b0;
    endfunction

    function void next_cycle_or_stop();
        if (alarm_req && (cycles_todo != 16'd0 || cycle_total == 16'd0))
        begin
            ph        = PH_ON;
            remaining = tone_len;
            tone      = 1'b1;
        end
        else
        begin
            alarm_req = 1'b0;
            to_poll_wait();
        end
    endfunction

    function void launch_alarm();
        cycles_todo = cycle_total;
        next_cycle_or_stop();
    endfunction

    function out_item_t advance_beeper(input in_item_t it);
        out_item_t r;
        logic      allowed;
        allowed = audible & present;
        case (it.kind)
            KIND_TICK:
            begin
                // zero-length phases end on the next tick, same as length one
                if (remaining > 16'd1)
                    remaining = remaining - 16'd1;
                else
                begin
                    case (ph)
                        PH_POLL:
                        begin
                            if (short_len != 16'd0)
                            begin
                                remaining = short_len;
                                short_len = 16'd0;
                                ph        = PH_SHORT;
                                tone      = 1'b1;
                            end
                            else if (alarm_req)
                                launch_alarm();
                            else
                                to_poll_wait();
                        end
                        PH_SHORT:
                        begin
                            tone = 1'b0;
                            if (alarm_req)
                                launch_alarm();
                            else
                                to_poll_wait();
                        end
                        PH_ON:
                        begin
                            tone      = 1'b0;
                            ph        = PH_OFF;
                            remaining = gap_len;
                        end
                        default:
                        begin
                            if (cycle_total != 16'd0 && cycles_todo != 16'd0)
                                cycles_todo = cycles_todo - 16'd1;
                            next_cycle_or_stop();
                        end
                    endcase
                end
            end
            KIND_SHORT:
            begin
                if (allowed)
                    short_len = (it.short_ms != 16'd0) ? it.short_ms : DEFAULT_SHORT;
            end
            KIND_ALARM:
            begin
                if (allowed)
                begin
                    tone_len    = it.on_ms;
                    gap_len     = it.off_ms;
                    cycle_total = it.repeat_count;
                    cycles_todo = it.repeat_count;
                    alarm_req   = 1'b1;
                    // restart at once when a cycle is running
                    if (ph == PH_ON || ph == PH_OFF)
                    begin
                        ph        = PH_ON;
                        remaining = tone_len;
                        tone      = 1'b1;
                    end
                end
            end
            default:
                alarm_req = 1'b0;
        endcase
        r.tone_on       = tone;
        r.alarm_active  = alarm_req;
        r.short_waiting = (short_len != 16'd0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            audible     = 1'b1;
            present     = 1'b1;
            ph          = PH_POLL;
            remaining   = POLL_TICKS;
            short_len   = 16'd0;
            tone_len    = 16'd0;
            gap_len     = 16'd0;
            cycle_total = 16'd0;
            cycles_todo = 16'd0;
            alarm_req   = 1'b0;
            tone        = 1'b0;
            predicted_outputs.delete();
            pending     = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_AUDIBLE)
                    audible = pwdata[0];
                else if (paddr == ADDR_PRESENT)
                    present = pwdata[0];
            end
            if (out_valid && !out_stall)
            begin
                if (predicted_outputs.size() == 0)
                    report("result with no item outstanding");
                else
                begin
                    want = predicted_outputs.pop_front();
                    if (out_item.tone_on !== want.tone_on)
                        report($sformatf("tone_on got %b expected %b",
                                         out_item.tone_on, want.tone_on));
                    if (out_item.alarm_active !== want.alarm_active)
                        report($sformatf("alarm_active got %b expected %b",
                                         out_item.alarm_active, want.alarm_active));
                    if (out_item.short_waiting !== want.short_waiting)
                        report($sformatf("short_waiting got %b expected %b",
                                         out_item.short_waiting, want.short_waiting));
                end
                checked++;
                if (out_item.tone_on === 1'b1)
                    tone_count++;
            end
            if (in_valid && !in_stall)
                predicted_outputs.push_back(advance_beeper(in_item));
            pending = predicted_outputs.size();
        end
    end

endmodule

// ===== dv/tb_beep_pattern_generator_top.sv =====
// Testbench top for the beeper pattern generator: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_beep_pattern_generator_top;
    import bpg_pkg::*;

    localparam int NUM_PHASES     = 6;
    localparam int PHASE_ITEMS    = 165;
    localparam int HOLD_CYCLES    = 240;
    localparam int WATCHDOG_LIMIT = 3000;
    // audible, present per phase
    localparam logic [1:0] ENABLE_SEQ [NUM_PHASES] = '{2'b11, 2'b01, 2'b11, 2'b10, 2'b00, 2'b11};

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_item_t               in_item   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_item;
    logic                   psel      = 1'b0;
    logic                   penable   = 1'b0;
    logic                   pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr     = '0;
    logic [31:0]            pwdata    = '0;
    logic [31:0]            prdata;
    logic                   pready;

    int errors;
    int pending;
    int checked;
    int tone_count;

    int items_sent = 0;
    int burst_left = 0;
    bit gaps_on    = 1'b0;
    int stall_mode = 0;
    bit hold_req   = 1'b0;
    int idle_cycles = 0;

    beep_pattern_generator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    beep_pattern_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked),
        .tone_count (tone_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // output side: stall pattern per mode, plus one long hold-off on request
    initial
    begin
        int pat_cnt;
        int hold_left;
        pat_cnt   = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 40);
                    2:
                    begin
                        pat_cnt = (pat_cnt + 1) % 5;
                        out_stall <= (pat_cnt < 2);
                    end
                    default: out_stall <= ($urandom_range(0, 99) < 80);
                endcase
            end
        end
    end

    // no handshake on any port for too long means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on)
            begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
                @(negedge clk) in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        burst_left--;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk) in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk) penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // unused fields stay random so every payload bit toggles
    function automatic in_item_t noisy_item(input logic [1:0] kind);
        in_item_t it;
        it.kind         = kind;
        it.short_ms     = 16'($urandom);
        it.on_ms        = 16'($urandom);
        it.off_ms       = 16'($urandom);
        it.repeat_count = 16'($urandom);
        return it;
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [15:0] short_ms,
                                input logic [15:0] on_ms, input logic [15:0] off_ms,
                                input logic [15:0] repeat_count);
        in_item_t it;
        it.kind         = kind;
        it.short_ms     = short_ms;
        it.on_ms        = on_ms;
        it.off_ms       = off_ms;
        it.repeat_count = repeat_count;
        send_item(it);
    endtask

    task automatic tick_run(input int n);
        repeat (n) send_item(noisy_item(KIND_TICK));
    endtask

    function automatic logic [15:0] pick_len();
        return ($urandom_range(0, 32) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    endfunction

    task automatic random_episode();
        in_item_t it;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            tick_run($urandom_range(1, 25));
        else if (pick < 67)
        begin
            it = noisy_item(KIND_SHORT);
            it.short_ms = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
            send_item(it);
        end
        else if (pick < 82)
        begin
            it = noisy_item(KIND_ALARM);
            it.on_ms  = pick_len();
            it.off_ms = pick_len();
            if ($urandom_range(0, 29) == 0)
                it.repeat_count = 16'($urandom);
            else if ($urandom_range(0, 9) < 4)
                it.repeat_count = 16'd0;
            else
                it.repeat_count = 16'($urandom_range(1, 4));
            send_item(it);
        end
        else if (pick < 90)
            send_item(noisy_item(KIND_STOP));
        else
        begin
            case ($urandom_range(0, 2))
                0: send_item(noisy_item(KIND_TICK));
                1: send_item(noisy_item(KIND_STOP));
                default: send_item(noisy_item(KIND_ALARM));
            endcase
        end
    endtask

    initial
    begin
        int directed_items;
        int start;
        bit held;
        bit paused;
        held   = 1'b0;
        paused = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed: default short, extreme lengths overwritten, zero-length alarm,
        // restart during a cycle, stop mid-cycle and while idle
        tick_run(3);
        send_request(KIND_SHORT, 16'd0, 16'd0, 16'd0, 16'd0);
        send_request(KIND_SHORT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(KIND_SHORT, 16'd1, 16'd0, 16'd0, 16'd0);
        send_request(KIND_ALARM, 16'd0, 16'd0, 16'd0, 16'd2);
        tick_run(30);
        send_request(KIND_ALARM, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        tick_run(24);
        send_request(KIND_ALARM, 16'd0, 16'd3, 16'd2, 16'd0);
        tick_run(8);
        send_request(KIND_STOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        tick_run(7);
        send_request(KIND_STOP, 16'd0, 16'd0, 16'd0, 16'd0);
        send_request(KIND_ALARM, 16'd0, 16'd1, 16'hFFFF, 16'd1);
        tick_run(22);
        send_request(KIND_ALARM, 16'd0, 16'd2, 16'd1, 16'd1);
        tick_run(6);
        send_request(KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(KIND_TICK, 16'd0, 16'd0, 16'd0, 16'd0);
        directed_items = items_sent;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            write_reg(ADDR_AUDIBLE, {31'd0, ENABLE_SEQ[p][1]});
            write_reg(ADDR_PRESENT, {31'd0, ENABLE_SEQ[p][0]});
            stall_mode = p % 4;
            gaps_on    = (p != 0);
            start      = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                if (p == 2 && !held && items_sent - start > PHASE_ITEMS / 3)
                begin
                    // long output hold-off while items keep coming
                    hold_req = 1'b1;
                    held     = 1'b1;
                end
                if (p == 5 && !paused && items_sent - start > PHASE_ITEMS / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                random_episode();
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Ran %0d items (%0d directed) over %0d enable settings; %0d results checked",
                 items_sent, directed_items, NUM_PHASES, checked);
        $display("Tone was on in %0d results; one %0d-cycle output hold-off, one full drain",
                 tone_count, HOLD_CYCLES);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
